// File: rtl/rgbds_pkg.sv
// Package for the RGB565 2x2 box downsampler.
// Holds tile geometry, counter and line store widths, and the channel pair-sum helper.
// No dependencies.
`default_nettype none
package rgbds_pkg;

  localparam int unsigned OUT_WIDTH  = 64;
  localparam int unsigned OUT_HEIGHT = 64;

  localparam int unsigned COL_W  = $clog2(2 * OUT_WIDTH);
  localparam int unsigned ROW_W  = $clog2(2 * OUT_HEIGHT);
  localparam int unsigned ADDR_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;

  localparam int unsigned CH_W  = 7;
  localparam int unsigned SUM_W = 3 * CH_W;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(2 * OUT_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(2 * OUT_HEIGHT - 1);

  typedef logic [SUM_W-1:0] pair_sum_t;

  function automatic pair_sum_t pack_pair(input logic [15:0] a, input logic [15:0] b);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] bl;
    r  = CH_W'(a[15:11]) + CH_W'(b[15:11]);
    g  = CH_W'(a[10:5]) + CH_W'(b[10:5]);
    bl = CH_W'(a[4:0]) + CH_W'(b[4:0]);
    return {r, g, bl};
  endfunction

endpackage
`default_nettype wire

// File: rtl/rgbds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none
module rgbds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgb565_2x2_box_downsample.sv
// Top level of the RGB565 2x2 box downsampler.
// Depends on rgbds_pkg and rgbds_ram (line store of column pair sums).
//
//   channel | payload              | handshake
//   --------+----------------------+----------------------------
//   in      | sample_i[15:0]       | in_valid_i / in_stall_o
//   out     | pixel_o, last_pixel_o| out_valid_o / out_stall_i
//
// One sample per cycle while in_stall_o is low; after its bottom-right sample is accepted,
// a pixel passes the line store read, then the output register.
// The line store is undefined after reset; every odd row reads entries the even row
// above it wrote. Counters and the left sample reset to zero.
// An out stall holds the read stage only when the output register is full.
`default_nettype none
module rgb565_2x2_box_downsample (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] sample_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic      [15:0] pixel_o,
  output logic             last_pixel_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);
  import rgbds_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [15:0]       left_q;
  logic              rd_valid_q;
  pair_sum_t         bottom_q;
  logic              last_q;
  logic              out_valid_q;
  logic [15:0]       pixel_q;
  logic              out_last_q;

  logic              accept;
  logic              rd_adv;
  logic              odd_col;
  logic              odd_row;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] idx;
  pair_sum_t         pair;
  pair_sum_t         top;
  logic [7:0]        sum_r, sum_g, sum_b;
  logic [15:0]       pixel_d;

  assign rd_adv     = rd_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = rd_valid_q && !rd_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign odd_col = col_q[0];
  assign odd_row = row_q[0];
  assign idx     = ADDR_W'(col_q >> 1);
  assign pair    = pack_pair(left_q, sample_i);
  assign wr_en   = accept && odd_col && !odd_row;
  assign rd_en   = accept && odd_col && odd_row;

  rgbds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (OUT_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx),
    .wdata_i (pair),
    .re_i    (rd_en),
    .raddr_i (idx),
    .rdata_o (top)
  );

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    sum_r   = 8'(top[3*CH_W-1:2*CH_W]) + 8'(bottom_q[3*CH_W-1:2*CH_W]) + 8'd2;
    sum_g   = 8'(top[2*CH_W-1:CH_W]) + 8'(bottom_q[2*CH_W-1:CH_W]) + 8'd2;
    sum_b   = 8'(top[CH_W-1:0]) + 8'(bottom_q[CH_W-1:0]) + 8'd2;
    pixel_d = {sum_r[6:2], sum_g[7:2], sum_b[6:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !odd_col) begin
        left_q <= sample_i;
      end
      if (rd_en) begin
        rd_valid_q <= 1'b1;
      end else if (rd_adv) begin
        rd_valid_q <= 1'b0;
      end
      if (rd_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bottom_q <= pair;
      last_q   <= (col_q == COL_LAST) && (row_q == ROW_LAST);
    end
    if (rd_adv) begin
      pixel_q    <= pixel_d;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_o      = pixel_q;
  assign last_pixel_o = out_last_q;

endmodule
`default_nettype wire
